// ===== rtl/lzd_pkg.sv =====
// Package for the LZ pair stream decoder: constants, codes and shared types.
// Used by every module of the block; depends on nothing.
package lzd_pkg;

    localparam int unsigned HISTORY_SIZE_DEF = 65536;
    localparam int unsigned MAX_LEN_DEF      = 64;
    localparam int unsigned LEN_W            = 7;

    localparam logic [7:0] COMMA_BYTE  = 8'h2C;
    localparam logic [7:0] EOF_BYTE    = 8'hFF;
    localparam logic [2:0] RECORD_LAST = 3'd7;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_OOB   = 2'd1,
        ERR_TRUNC = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        MD_LITERAL = 2'd0,
        MD_WAIT    = 2'd1,
        MD_RECORD  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_EMIT = 2'd2
    } t_back_state;

    typedef struct packed {
        logic             is_lit;
        logic [7:0]       data;
        logic [31:0]      offset;
        logic [LEN_W-1:0] len;
        logic             trunc;
    } t_cmd;

endpackage

// ===== rtl/lzd_if.sv =====
// Handshake interfaces for the decoder's input and output words.
// Depends on nothing outside this file.
interface lzd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface lzd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic [1:0] error_code;

    modport source (output valid, output out_byte, output last_of_run, output error_code,
                    input ready);
    modport sink   (input valid, input out_byte, input last_of_run, input error_code,
                    output ready);
endinterface

// ===== rtl/lzd_front.sv =====
// Front end: accepts input words, tracks literal/record mode, builds commands.
// Depends on lzd_pkg and lzd_in_if.
module lzd_front #(
    parameter int unsigned MAX_LEN = lzd_pkg::MAX_LEN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lzd_in_if.sink        i_in,
    input  logic          i_q_ready,
    output logic          o_push,
    output lzd_pkg::t_cmd o_cmd
);

    lzd_pkg::t_mode r_mode, n_mode;
    logic [2:0]     r_cnt;
    logic [31:0]    r_off;
    logic [31:0]    r_len;

    logic        acc;
    logic        is_comma;
    logic [4:0]  sh;
    logic [31:0] full_len;

    assign i_in.ready = i_q_ready;
    assign acc        = i_in.valid & i_q_ready;
    assign is_comma   = (i_in.in_byte == lzd_pkg::COMMA_BYTE);
    assign sh         = {r_cnt[1:0], 3'b000};
    assign full_len   = {i_in.in_byte, r_len[23:0]};

    always_comb begin
        n_mode = r_mode;
        if (acc) begin
            case (r_mode)
                lzd_pkg::MD_WAIT: begin
                    n_mode = is_comma ? lzd_pkg::MD_LITERAL : lzd_pkg::MD_RECORD;
                end
                lzd_pkg::MD_RECORD: begin
                    if (r_cnt == lzd_pkg::RECORD_LAST) begin
                        n_mode = lzd_pkg::MD_WAIT;
                    end
                end
                default: begin
                    n_mode = is_comma ? lzd_pkg::MD_WAIT : lzd_pkg::MD_LITERAL;
                end
            endcase
        end
    end

    always_comb begin
        o_push        = 1'b0;
        o_cmd.is_lit  = 1'b0;
        o_cmd.data    = i_in.in_byte;
        o_cmd.offset  = r_off;
        o_cmd.len     = full_len[lzd_pkg::LEN_W-1:0];
        o_cmd.trunc   = 1'b0;
        if (full_len > 32'(MAX_LEN)) begin
            o_cmd.len   = lzd_pkg::LEN_W'(MAX_LEN);
            o_cmd.trunc = 1'b1;
        end
        case (r_mode)
            lzd_pkg::MD_WAIT: begin
                o_push = 1'b0;
            end
            lzd_pkg::MD_RECORD: begin
                o_push = acc && (r_cnt == lzd_pkg::RECORD_LAST) && (full_len != 32'd0);
            end
            default: begin
                o_cmd.is_lit = 1'b1;
                o_push       = acc && !is_comma;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= lzd_pkg::MD_LITERAL;
            r_cnt  <= 3'd0;
            r_off  <= 32'd0;
            r_len  <= 32'd0;
        end else begin
            r_mode <= n_mode;
            if (acc) begin
                case (r_mode)
                    lzd_pkg::MD_WAIT: begin
                        if (!is_comma) begin
                            r_off <= {24'd0, i_in.in_byte};
                            r_len <= 32'd0;
                            r_cnt <= 3'd1;
                        end
                    end
                    lzd_pkg::MD_RECORD: begin
                        if (!r_cnt[2]) begin
                            r_off <= (r_off & ~(32'hFF << sh)) | ({24'd0, i_in.in_byte} << sh);
                        end else begin
                            r_len <= (r_len & ~(32'hFF << sh)) | ({24'd0, i_in.in_byte} << sh);
                        end
                        r_cnt <= r_cnt + 3'd1;
                    end
                    default: begin
                        r_cnt <= 3'd0;
                    end
                endcase
            end
        end
    end

endmodule

// ===== rtl/lzd_cmd_queue.sv =====
// Two-entry command queue between the front end and the copy engine.
// Depends on lzd_pkg.
module lzd_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lzd_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output lzd_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    lzd_pkg::t_cmd r_ent [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    logic do_push;
    logic do_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_ent[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/lzd_back.sv =====
// Copy engine: emits literals and history copies, keeps the output history.
// Depends on lzd_pkg and lzd_out_if.
module lzd_back #(
    parameter int unsigned HISTORY_SIZE = lzd_pkg::HISTORY_SIZE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  lzd_pkg::t_cmd i_cmd,
    output logic          o_pop,
    lzd_out_if.source     o_out
);

    localparam int unsigned AW   = $clog2(HISTORY_SIZE);
    localparam int unsigned WC_W = $clog2(HISTORY_SIZE + 1);

    logic [7:0] r_mem [HISTORY_SIZE];

    lzd_pkg::t_back_state r_state, n_state;

    logic [WC_W-1:0]          r_wc;
    logic [32:0]              r_src;
    logic [lzd_pkg::LEN_W-1:0] r_left;
    logic                     r_trunc;
    logic                     r_is_lit;
    logic [7:0]               r_lit;
    logic                     r_oob;
    logic [7:0]               r_rd_data;

    logic                     r_out_valid;
    logic [7:0]               r_out_byte;
    logic                     r_out_last;
    lzd_pkg::t_err            r_out_err;

    logic          out_free;
    logic          emit;
    logic          last;
    logic          mem_we;
    logic [7:0]    emit_byte;
    lzd_pkg::t_err emit_err;

    assign out_free = !r_out_valid || o_out.ready;
    assign last     = r_is_lit || (r_left == lzd_pkg::LEN_W'(1));

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.last_of_run = r_out_last;
    assign o_out.error_code  = r_out_err;

    always_comb begin
        n_state = r_state;
        case (r_state)
            lzd_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = i_cmd.is_lit ? lzd_pkg::BK_EMIT : lzd_pkg::BK_READ;
                end
            end
            lzd_pkg::BK_READ: begin
                n_state = lzd_pkg::BK_EMIT;
            end
            lzd_pkg::BK_EMIT: begin
                if (out_free) begin
                    n_state = last ? lzd_pkg::BK_IDLE : lzd_pkg::BK_READ;
                end
            end
            default: begin
                n_state = lzd_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        emit      = 1'b0;
        emit_byte = r_lit;
        emit_err  = lzd_pkg::ERR_OK;
        if (!r_is_lit) begin
            if (r_oob) begin
                emit_byte = lzd_pkg::EOF_BYTE;
                emit_err  = lzd_pkg::ERR_OOB;
            end else begin
                emit_byte = r_rd_data;
                emit_err  = r_trunc ? lzd_pkg::ERR_TRUNC : lzd_pkg::ERR_OK;
            end
        end
        case (r_state)
            lzd_pkg::BK_IDLE: o_pop = i_q_valid;
            lzd_pkg::BK_EMIT: emit  = out_free;
            default:          emit  = 1'b0;
        endcase
    end

    assign mem_we = emit && (r_wc < WC_W'(HISTORY_SIZE));

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_src[AW-1:0]];
        if (mem_we) begin
            r_mem[r_wc[AW-1:0]] <= emit_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lzd_pkg::BK_IDLE;
            r_wc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mem_we) begin
                r_wc <= r_wc + WC_W'(1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_is_lit <= i_cmd.is_lit;
            r_lit    <= i_cmd.data;
            r_src    <= {1'b0, i_cmd.offset};
            r_left   <= i_cmd.len;
            r_trunc  <= i_cmd.trunc;
        end
        if (r_state == lzd_pkg::BK_READ) begin
            r_oob <= (r_src >= 33'(r_wc));
        end
        if (emit) begin
            r_out_byte <= emit_byte;
            r_out_last <= last;
            r_out_err  <= emit_err;
            r_src      <= r_src + 33'd1;
            r_left     <= r_left - lzd_pkg::LEN_W'(1);
        end
    end

endmodule

// ===== rtl/lz_pair_stream_decoder.sv =====
// LZ pair stream decoder: one compressed byte per input word, one decoded byte per
// output word. The front end takes an input word each cycle while its two-entry
// command queue has room; commas and record bytes that do not close a record make
// no output. The copy engine fetches a command only when idle; for each output byte
// of a copy it does a history read followed by the write and output load, while a
// literal goes straight to the write and output load. A copy's length is capped
// at MAX_LEN; sources at or past the written count return 0xFF.
// Depends on lzd_pkg, lzd_if, lzd_front, lzd_cmd_queue and lzd_back.
module lz_pair_stream_decoder #(
    parameter int unsigned HISTORY_SIZE = lzd_pkg::HISTORY_SIZE_DEF,
    parameter int unsigned MAX_LEN      = lzd_pkg::MAX_LEN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lzd_in_if.sink    i_in,
    lzd_out_if.source o_out
);

    logic          push;
    lzd_pkg::t_cmd push_cmd;
    logic          q_ready;
    logic          q_valid;
    lzd_pkg::t_cmd q_cmd;
    logic          pop;

    lzd_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    lzd_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    lzd_back #(
        .HISTORY_SIZE (HISTORY_SIZE)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
